@@ design/tle_pkg.sv @@
package tle_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 6;
  localparam int LIMIT_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [BYTE_W-1:0] BYTE_LF      = 8'h0a;
  localparam logic [BYTE_W-1:0] BYTE_CR      = 8'h0d;
  localparam logic [BYTE_W-1:0] BYTE_BS      = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h1b;
  localparam logic [BYTE_W-1:0] BYTE_BRACKET = 8'h5b;
  localparam logic [BYTE_W-1:0] BYTE_LEFT    = 8'h44;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // line store access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [POS_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  index;
    logic              last;
  } result_t;

endpackage

@@ design/tle_line_mem.sv @@
module tle_line_mem #(
  parameter int LINE_MAX = 32
) (
  input  logic                          clk_i,
  input  tle_pkg::mem_req_t             req_i,
  output logic [tle_pkg::BYTE_W-1:0]    rd_data_o
);

  localparam int AW = $clog2(LINE_MAX);

  logic [tle_pkg::BYTE_W-1:0] mem_q [LINE_MAX];
  logic [tle_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/tle_ctrl.sv @@
module tle_ctrl #(
  parameter int LINE_MAX = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tle_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tle_pkg::BYTE_W-1:0]    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tle_pkg::result_t              out_o,
  output tle_pkg::mem_req_t             mem_req_o,
  input  logic [tle_pkg::BYTE_W-1:0]    mem_rdata_i
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam logic [tle_pkg::LIMIT_W-1:0] LIMIT_MAX = tle_pkg::LIMIT_W'(LINE_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_RADDR,
    ST_RDATA,
    ST_END
  } state_e;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_SEEN,
    ESC_BRACKET
  } esc_e;

  state_e                     state_q;
  esc_e                       esc_q;
  logic [CW-1:0]              cursor_q;
  logic [CW-1:0]              rd_idx_q;
  logic [tle_pkg::BYTE_W-1:0] echo_byte_q;
  logic                       readout_q;
  logic                       out_valid_q;
  tle_pkg::result_t           out_q;

  logic                         accept;
  logic                         slot_free;
  logic                         is_eol;
  logic                         is_bs;
  logic                         is_print;
  logic                         is_esc;
  logic                         print_ends;
  logic [tle_pkg::LIMIT_W-1:0]  lim_eff;
  logic [tle_pkg::LIMIT_W:0]    cursor_inc;
  logic [CW-1:0]                rd_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    is_eol   = (in_byte_i == tle_pkg::BYTE_LF) || (in_byte_i == tle_pkg::BYTE_CR);
    is_bs    = (in_byte_i == tle_pkg::BYTE_BS) && (cursor_q != '0);
    is_print = (in_byte_i >= tle_pkg::BYTE_SPACE);
    is_esc   = (in_byte_i == tle_pkg::BYTE_ESC);
    priority if (limit_i == '0) begin
      lim_eff = tle_pkg::LIMIT_W'(1);
    end else if (limit_i > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end else begin
      lim_eff = limit_i;
    end
    cursor_inc = (tle_pkg::LIMIT_W + 1)'(cursor_q) + (tle_pkg::LIMIT_W + 1)'(1);
    print_ends = (cursor_inc >= {1'b0, lim_eff});
    rd_next    = rd_idx_q + CW'(1);
  end

  // store printable bytes on accept; read issued from ST_RADDR, after the last write
  always_comb begin
    mem_req_o.we    = accept && (esc_q == ESC_NONE) && is_print &&
                      ((tle_pkg::LIMIT_W + 1)'(cursor_q) < (tle_pkg::LIMIT_W + 1)'(LINE_MAX));
    mem_req_o.waddr = tle_pkg::POS_W'(cursor_q);
    mem_req_o.wdata = in_byte_i;
    mem_req_o.re    = (state_q == ST_RADDR);
    mem_req_o.raddr = tle_pkg::POS_W'(rd_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      esc_q       <= ESC_NONE;
      cursor_q    <= '0;
      rd_idx_q    <= '0;
      echo_byte_q <= '0;
      readout_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (esc_q)
              ESC_SEEN: begin
                esc_q <= (in_byte_i == tle_pkg::BYTE_BRACKET) ? ESC_BRACKET : ESC_NONE;
              end
              ESC_BRACKET: begin
                esc_q <= ESC_NONE;
                if ((in_byte_i == tle_pkg::BYTE_LEFT) && (cursor_q != '0)) begin
                  echo_byte_q <= tle_pkg::BYTE_BS;
                  readout_q   <= 1'b0;
                  cursor_q    <= cursor_q - CW'(1);
                  state_q     <= ST_ECHO;
                end
              end
              ESC_NONE: begin
                priority if (is_eol) begin
                  echo_byte_q <= in_byte_i;
                  readout_q   <= 1'b1;
                  state_q     <= ST_ECHO;
                end else if (is_bs) begin
                  echo_byte_q <= in_byte_i;
                  readout_q   <= 1'b0;
                  cursor_q    <= cursor_q - CW'(1);
                  state_q     <= ST_ECHO;
                end else if (is_print) begin
                  echo_byte_q <= in_byte_i;
                  readout_q   <= print_ends;
                  cursor_q    <= CW'(cursor_inc);
                  state_q     <= ST_ECHO;
                end else if (is_esc) begin
                  esc_q <= ESC_SEEN;
                end else begin
                  // other control bytes and backspace on an empty line: no effect
                  esc_q <= ESC_NONE;
                end
              end
              default: begin
                esc_q <= ESC_NONE;
              end
            endcase
          end
        end
        ST_ECHO: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q.kind  <= tle_pkg::KIND_ECHO;
            out_q.data  <= echo_byte_q;
            out_q.index <= '0;
            out_q.last  <= !readout_q;
            rd_idx_q    <= '0;
            if (!readout_q) begin
              state_q <= ST_IDLE;
            end else if (cursor_q == '0) begin
              state_q <= ST_END;
            end else begin
              state_q <= ST_RADDR;
            end
          end
        end
        ST_RADDR: begin
          state_q <= ST_RDATA;
        end
        ST_RDATA: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q.kind  <= tle_pkg::KIND_CHAR;
            out_q.data  <= mem_rdata_i;
            out_q.index <= tle_pkg::POS_W'(rd_idx_q);
            out_q.last  <= 1'b0;
            rd_idx_q    <= rd_next;
            state_q     <= (rd_next == cursor_q) ? ST_END : ST_RADDR;
          end
        end
        ST_END: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_q.kind  <= tle_pkg::KIND_END;
            out_q.data  <= '0;
            out_q.index <= tle_pkg::POS_W'(cursor_q);
            out_q.last  <= 1'b1;
            cursor_q    <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ design/terminal_line_editor_core.sv @@
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: rx_byte
// m_axis    out  m_axis_tvalid/tready       tdata: out_byte, out_index; tuser: out_kind;
//                                           tlast: last
// cfg       in   cfg_we (no wait)           cfg_wdata: line_limit
//
// A dropped or ignored byte is handled in ST_IDLE alone; an echoed byte also
// passes ST_ECHO. A line end of n characters passes ST_ECHO, then for each
// character a line-store read and an output register load, then ST_END.
// Reset clears cursor and escape state and sets the limit to 32; the line store
// is not cleared, only entries below the cursor are ever read.
// Output stalls hold the sequencer; the output register lets the next byte be
// taken while the final result of the previous one still waits.
module terminal_line_editor_core #(
  parameter int LINE_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: line_limit [5:0]
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // receive stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [13:8] out_index, [15:14] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] out_kind
  output logic        m_axis_tlast_o
);

  logic [tle_pkg::LIMIT_W-1:0] line_limit_q;
  tle_pkg::mem_req_t           mem_req;
  logic [tle_pkg::BYTE_W-1:0]  mem_rdata;
  tle_pkg::result_t            result;

  // line_limit register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= tle_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      line_limit_q <= cfg_wdata_i;
    end
  end

  // line store: one entry per character position
  tle_line_mem #(
    .LINE_MAX (LINE_MAX)
  ) u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rdata)
  );

  // byte decode, escape tracking and line readout sequencer
  tle_ctrl #(
    .LINE_MAX (LINE_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (line_limit_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  assign m_axis_tdata_o = {2'b00, result.index, result.data};
  assign m_axis_tuser_o = result.kind;
  assign m_axis_tlast_o = result.last;

  // a line end always closes the transfer group and carries no byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == tle_pkg::KIND_END))
      |-> (m_axis_tlast_o && (m_axis_tdata_o[7:0] == 8'h00)))
    else $error("line end without tlast or with nonzero byte");

  // line characters come from stored positions and never end the group
  a_char_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == tle_pkg::KIND_CHAR))
      |-> (!m_axis_tlast_o && (32'(m_axis_tdata_o[13:8]) < LINE_MAX)))
    else $error("line character index out of range or marked last");

  // echoes carry index zero
  a_echo_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == tle_pkg::KIND_ECHO))
      |-> (m_axis_tdata_o[13:8] == 6'd0))
    else $error("echo with nonzero index");

  // no unused kind code ever leaves the block
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == tle_pkg::KIND_ECHO) ||
                         (m_axis_tuser_o == tle_pkg::KIND_CHAR) ||
                         (m_axis_tuser_o == tle_pkg::KIND_END)))
    else $error("undefined result kind");

endmodule
